// ----- sv/sctp_pkg.sv -----
package sctp_pkg;

  localparam int unsigned MaxTripletsDefault = 31;
  localparam int unsigned FfCap              = 1 << 20;
  localparam int unsigned CcHeaderLen        = 10;
  localparam int unsigned TripletW           = 19;

  typedef struct packed {
    logic [7:0] nal_byte;
    logic       end_of_unit;
  } in_item_t;

  typedef struct packed {
    logic [1:0] cc_type;
    logic       cc_valid;
    logic [7:0] cc_first_byte;
    logic [7:0] cc_second_byte;
    logic       last_in_run;
  } out_item_t;

  // request from the parser to the emitter: play back a run of stored triplets
  typedef struct packed {
    logic [4:0] count;
  } run_req_t;

  function automatic logic [7:0] cc_header_byte(input logic [2:0] idx);
    logic [7:0] r;
    case (idx)
      3'd0:    r = 8'hB5;
      3'd1:    r = 8'h00;
      3'd2:    r = 8'h31;
      3'd3:    r = 8'h47;
      3'd4:    r = 8'h41;
      3'd5:    r = 8'h39;
      3'd6:    r = 8'h34;
      default: r = 8'h03;
    endcase
    return r;
  endfunction

endpackage

// ----- sv/sctp_ram.sv -----
module sctp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- sv/sctp_front.sv -----
module sctp_front #(
  parameter int unsigned MaxTriplets = 31
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [4:0]         sei_unit_type_i,
  input  logic               in_fire_i,
  input  sctp_pkg::in_item_t in_item_i,
  // store write port
  output logic               st_we_o,
  output logic [4:0]         st_waddr_o,
  output logic [18:0]        st_wdata_o,
  // completed run towards the back part
  output logic               run_push_o,
  output sctp_pkg::run_req_t run_o
);
  import sctp_pkg::*;

  localparam logic [2:0] PhHeader = 3'd0;
  localparam logic [2:0] PhType   = 3'd1;
  localparam logic [2:0] PhSize   = 3'd2;
  localparam logic [2:0] PhBody   = 3'd3;
  localparam logic [2:0] PhIdle   = 3'd4;
  localparam logic [4:0] MaxT     = 5'(MaxTriplets);

  logic [1:0]  zero_run_q, zero_run_d;
  logic [2:0]  phase_q, phase_d;
  logic [20:0] ff_total_q, ff_total_d;
  logic        is_cc_q, is_cc_d;
  logic [20:0] left_q, left_d;
  logic [3:0]  bidx_q, bidx_d;
  logic        hdr_ok_q, hdr_ok_d;
  logic [4:0]  target_q, target_d;
  logic [1:0]  tph_q, tph_d;
  logic [10:0] part_q, part_d;
  logic [4:0]  count_q, count_d;

  logic [7:0]  b;
  logic        drop;
  logic [21:0] ff_sum;
  logic [21:0] v;
  logic [4:0]  c;

  assign b      = in_item_i.nal_byte;
  assign drop   = (zero_run_q == 2'd2) && (b == 8'h03);
  assign ff_sum = {1'b0, ff_total_q} + 22'd255;
  assign v      = {1'b0, ff_total_q} + {14'd0, b};
  assign c      = (b[4:0] > MaxT) ? MaxT : b[4:0];

  // byte parser, one rbsp byte a cycle while in_fire_i is high
  always_comb begin
    zero_run_d = zero_run_q;
    phase_d    = phase_q;
    ff_total_d = ff_total_q;
    is_cc_d    = is_cc_q;
    left_d     = left_q;
    bidx_d     = bidx_q;
    hdr_ok_d   = hdr_ok_q;
    target_d   = target_q;
    tph_d      = tph_q;
    part_d     = part_q;
    count_d    = count_q;
    st_we_o    = 1'b0;
    st_waddr_o = count_q;
    st_wdata_o = {part_q, b};
    run_push_o = 1'b0;
    run_o.count = count_q;
    if (in_fire_i) begin
      if (drop) begin
        zero_run_d = 2'd0;
      end else begin
        zero_run_d = (b != 8'h00) ? 2'd0 : ((zero_run_q < 2'd2) ? zero_run_q + 2'd1 : 2'd2);
        case (phase_q)
          PhHeader: begin
            phase_d = (b[4:0] == sei_unit_type_i) ? PhType : PhIdle;
          end
          PhType, PhSize: begin
            if (b == 8'hFF) begin
              ff_total_d = ff_sum[20:0];
              if (ff_sum > 22'(FfCap)) begin
                phase_d = PhIdle;
              end
            end else begin
              ff_total_d = '0;
              if (phase_q == PhType) begin
                is_cc_d = (v == 22'd4);
                phase_d = PhSize;
              end else begin
                left_d   = v[20:0];
                bidx_d   = '0;
                hdr_ok_d = 1'b1;
                target_d = '0;
                tph_d    = '0;
                part_d   = '0;
                count_d  = '0;
                phase_d  = (v == 22'd0) ? PhType : PhBody;
              end
            end
          end
          PhBody: begin
            if (is_cc_q && hdr_ok_q) begin
              if (bidx_q < 4'(CcHeaderLen)) begin
                if (bidx_q < 4'd8) begin
                  if (b != cc_header_byte(bidx_q[2:0])) hdr_ok_d = 1'b0;
                end else if (bidx_q == 4'd8) begin
                  if (!b[6]) hdr_ok_d = 1'b0;
                  else target_d = c;
                end
                bidx_d = bidx_q + 4'd1;
              end else begin
                case (tph_q)
                  2'd0: begin
                    part_d = {b[2:0], 8'h00};
                    tph_d  = 2'd1;
                  end
                  2'd1: begin
                    part_d = {part_q[10:8], b};
                    tph_d  = 2'd2;
                  end
                  default: begin
                    if (count_q < target_q) begin
                      st_we_o = 1'b1;
                      count_d = count_q + 5'd1;
                    end
                    tph_d = 2'd0;
                  end
                endcase
              end
            end
            left_d = left_q - 21'd1;
            if (left_q == 21'd1) begin
              phase_d = PhType;
              run_push_o = is_cc_q && hdr_ok_d && (bidx_d >= 4'(CcHeaderLen)) &&
                           (count_d != 5'd0);
              run_o.count = count_d;
            end
          end
          default: ;
        endcase
      end
      if (in_item_i.end_of_unit) begin
        zero_run_d = '0;
        phase_d    = PhHeader;
        ff_total_d = '0;
        is_cc_d    = 1'b0;
        left_d     = '0;
        bidx_d     = '0;
        hdr_ok_d   = 1'b0;
        target_d   = '0;
        tph_d      = '0;
        part_d     = '0;
        count_d    = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_run_q <= '0;
      phase_q    <= PhHeader;
      ff_total_q <= '0;
      is_cc_q    <= 1'b0;
      left_q     <= '0;
      bidx_q     <= '0;
      hdr_ok_q   <= 1'b0;
      target_q   <= '0;
      tph_q      <= '0;
      part_q     <= '0;
      count_q    <= '0;
    end else begin
      zero_run_q <= zero_run_d;
      phase_q    <= phase_d;
      ff_total_q <= ff_total_d;
      is_cc_q    <= is_cc_d;
      left_q     <= left_d;
      bidx_q     <= bidx_d;
      hdr_ok_q   <= hdr_ok_d;
      target_q   <= target_d;
      tph_q      <= tph_d;
      part_q     <= part_d;
      count_q    <= count_d;
    end
  end

endmodule

// ----- sv/sctp_back.sv -----
module sctp_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                run_push_i,
  input  sctp_pkg::run_req_t  run_i,
  output logic                busy_o,
  output logic [4:0]          st_raddr_o,
  input  logic [18:0]         st_rdata_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sctp_pkg::out_item_t out_item_o
);
  import sctp_pkg::*;

  // run queue of depth one, then a read pipeline with output register
  logic       busy_q, busy_d;
  logic [4:0] total_q, total_d;
  logic [4:0] rd_q, rd_d;
  logic       pend_q, pend_d;
  logic       plast_q, plast_d;
  logic       ov_q, ov_d;
  out_item_t  oi_q, oi_d;
  logic       issue;
  logic       slot;

  assign slot  = !ov_q || out_ready_i;
  // a read may issue when neither the read stage nor output is blocked
  assign issue = busy_q && !pend_q && slot;
  assign st_raddr_o = rd_q;
  assign busy_o = busy_q;
  assign out_valid_o = ov_q;
  assign out_item_o  = oi_q;

  always_comb begin
    busy_d  = busy_q;
    total_d = total_q;
    rd_d    = rd_q;
    pend_d  = pend_q;
    plast_d = plast_q;
    ov_d    = ov_q;
    oi_d    = oi_q;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    if (pend_q && slot) begin
      ov_d = 1'b1;
      oi_d.cc_type        = st_rdata_i[17:16];
      oi_d.cc_valid       = st_rdata_i[18];
      oi_d.cc_first_byte  = st_rdata_i[15:8];
      oi_d.cc_second_byte = st_rdata_i[7:0];
      oi_d.last_in_run    = plast_q;
      pend_d = 1'b0;
    end
    if (issue) begin
      pend_d  = 1'b1;
      plast_d = (rd_q + 5'd1 == total_q);
      rd_d    = rd_q + 5'd1;
      if (rd_q + 5'd1 == total_q) busy_d = 1'b0;
    end
    if (run_push_i) begin
      busy_d  = 1'b1;
      total_d = run_i.count;
      rd_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      total_q <= '0;
      rd_q    <= '0;
      pend_q  <= 1'b0;
      plast_q <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      total_q <= total_d;
      rd_q    <= rd_d;
      pend_q  <= pend_d;
      plast_q <= plast_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    oi_q <= oi_d;
  end

endmodule

// ----- sv/sei_caption_triplet_parser_unit.sv -----
// Playback: each triplet of a run is read from the store, then registered;
//   a read issues only after the previous one has left the read stage.
// Throughput: one byte per cycle outside playback; a run holds off input until the
//   read of its last triplet has issued, longer while the output stalls.
// Reset: asynchronous, active low; clears parser and playback state and sets
//   the unit type register to 6. The triplet store is not cleared.
module sei_caption_triplet_parser_unit #(
  parameter int unsigned MAX_TRIPLETS = sctp_pkg::MaxTripletsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [4:0]          cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sctp_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sctp_pkg::out_item_t out_item_o
);
  import sctp_pkg::*;

  logic [4:0]  unit_type_q;
  logic        in_fire;
  logic        st_we;
  logic [4:0]  st_waddr, st_raddr;
  logic [18:0] st_wdata, st_rdata;
  logic        run_push;
  run_req_t    run;
  logic        busy;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) unit_type_q <= 5'd6;
    else if (cfg_we_i) unit_type_q <= cfg_wdata_i;
  end

  // store is reused per payload, so no bytes while a run plays
  assign in_ready_o = !busy;
  assign in_fire    = in_valid_i && in_ready_o;

  sctp_front #(.MaxTriplets(MAX_TRIPLETS)) u_front (
    .clk_i, .rst_ni,
    .sei_unit_type_i(unit_type_q),
    .in_fire_i(in_fire), .in_item_i,
    .st_we_o(st_we), .st_waddr_o(st_waddr), .st_wdata_o(st_wdata),
    .run_push_o(run_push), .run_o(run)
  );

  sctp_ram #(.Width(TripletW), .Depth(32)) u_store (
    .clk_i, .we_i(st_we), .waddr_i(st_waddr), .wdata_i(st_wdata),
    .raddr_i(st_raddr), .rdata_o(st_rdata)
  );

  sctp_back u_back (
    .clk_i, .rst_ni,
    .run_push_i(run_push), .run_i(run), .busy_o(busy),
    .st_raddr_o(st_raddr), .st_rdata_i(st_rdata),
    .out_valid_o, .out_ready_i, .out_item_o
  );

  a_no_in_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !in_fire) else $error("byte taken during playback");
  a_run_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_push |-> run.count != 5'd0) else $error("empty run pushed");
  a_push_only_on_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_push |-> in_fire) else $error("run pushed without a byte");

endmodule
